// ===== rtl/sv39_pkg.sv =====
package sv39_pkg;
	localparam int STORE_WORDS_DEF = 4096;
	localparam int PPN_W = 44;
	localparam int PA_W = 56;
	localparam int CFG_W = 44;
	localparam int CFG_IDX_W = 3;

	localparam logic [2:0] CFG_XLATE_ON = 3'd0;
	localparam logic [2:0] CFG_ROOT_PPN = 3'd1;
	localparam logic [2:0] CFG_CUR_PRIV = 3'd2;
	localparam logic [2:0] CFG_MPRV = 3'd3;
	localparam logic [2:0] CFG_PREV_PRIV = 3'd4;
	localparam logic [2:0] CFG_SUM = 3'd5;
	localparam logic [2:0] CFG_MXR = 3'd6;

	localparam logic [1:0] ST_DIRECT = 2'd0;
	localparam logic [1:0] ST_XLATE = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_STORE = 2'd1;
	localparam logic [1:0] KIND_FETCH = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_XLATE = 1'b1;

	// classified job handed from front to back
	typedef struct packed {
		logic        is_write;
		logic        walk;      // 0: result already known (direct or fault)
		logic [1:0]  status;
		logic [1:0]  kind;
		logic [1:0]  priv;
		logic [38:0] va;
		logic [11:0] widx;
		logic [63:0] wdata;
	} job_t;

	typedef struct packed {
		logic        sum;
		logic        mxr;
		logic [43:0] root_ppn;
	} cfg_t;
endpackage

// ===== rtl/sv39_if.sv =====
interface sv39_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [63:0] virt_addr;
	logic [1:0]  access_kind;
	logic [11:0] word_index;
	logic [63:0] word_data;
	modport source(output valid, opcode, virt_addr, access_kind, word_index, word_data,
		input ready);
	modport sink(input valid, opcode, virt_addr, access_kind, word_index, word_data,
		output ready);
endinterface

interface sv39_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [55:0] phys_addr;
	modport source(output valid, status, phys_addr, input ready);
	modport sink(input valid, status, phys_addr, output ready);
endinterface

// ===== rtl/sv39_page_walk_translate.sv =====
// Sv39 translator with an internal page-table word store.
// Channels: in_ch carries write items (opcode 0: word_index, word_data)
// and translate items (opcode 1: virt_addr, access_kind); out_ch gives one
// result (status, phys_addr) per translate item. Write items give none.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// A front stage classifies items (direct, non-canonical fault, walk) and
// pushes them into a two-entry queue; the back sequencer performs the walk.
// A direct or early-fault result passes through the queue and then the
// result register; a walk runs, for each level, an address, a memory read
// and a check step, and stops at a leaf, a fault, or a table address
// outside the store. Writes and direct items are taken one per cycle while
// the receiver takes results and no walk is in progress; a walk holds the
// sequencer until it ends, and the sequencer takes no new item meanwhile.
// Reset clears the configuration to machine mode, translation off, and
// empties the queue and result register; table contents stay undefined.
// When the receiver stalls, the result is held and the queue fills, then
// in_ch.ready drops.
module sv39_page_walk_translate #(
	parameter int STORE_WORDS = sv39_pkg::STORE_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sv39_in_if.sink     in_ch,
	sv39_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [43:0] cfg_data
);
	import sv39_pkg::*;

	cfg_t cfg;
	job_t f_job, b_job;
	logic f_valid, f_ready, b_valid, b_ready;

	sv39_front u_front (
		.clk, .arst_n, .in_ch, .cfg_we, .cfg_index, .cfg_data, .cfg,
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	sv39_fifo u_fifo (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
		.out_valid(b_valid), .out_ready(b_ready), .out_job(b_job)
	);

	sv39_back #(.STORE_WORDS(STORE_WORDS)) u_back (
		.clk, .arst_n, .cfg, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
		.out_ch
	);
endmodule

// ===== rtl/sv39_front.sv =====
module sv39_front (
	input  logic                   clk,
	input  logic                   arst_n,
	sv39_in_if.sink                in_ch,
	input  logic                   cfg_we,
	input  logic [2:0]             cfg_index,
	input  logic [43:0]            cfg_data,
	output sv39_pkg::cfg_t         cfg,
	output logic                   job_valid,
	input  logic                   job_ready,
	output sv39_pkg::job_t         job
);
	import sv39_pkg::*;

	logic        xlate_on_q, mprv_q, sum_q, mxr_q;
	logic [1:0]  cur_priv_q, prev_priv_q;
	logic [43:0] root_q;
	logic [1:0]  kind, priv;
	logic [25:0] top;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xlate_on_q <= 1'b0; root_q <= '0; cur_priv_q <= 2'd3;
			mprv_q <= 1'b0; prev_priv_q <= 2'd0; sum_q <= 1'b0; mxr_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_XLATE_ON:  xlate_on_q <= cfg_data[0];
				CFG_ROOT_PPN:  root_q <= cfg_data;
				CFG_CUR_PRIV:  cur_priv_q <= cfg_data[1:0];
				CFG_MPRV:      mprv_q <= cfg_data[0];
				CFG_PREV_PRIV: prev_priv_q <= cfg_data[1:0];
				CFG_SUM:       sum_q <= cfg_data[0];
				CFG_MXR:       mxr_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = '{sum: sum_q, mxr: mxr_q, root_ppn: root_q};

	// classify: direct, non-canonical fault, or walk
	always_comb begin
		kind = (in_ch.access_kind == 2'd3) ? KIND_LOAD : in_ch.access_kind;
		priv = (kind != KIND_FETCH && mprv_q) ? prev_priv_q : cur_priv_q;
		top = in_ch.virt_addr[63:38];
		job.is_write = (in_ch.opcode == OP_WRITE);
		job.kind = kind;
		job.priv = priv;
		job.va = in_ch.virt_addr[38:0];
		job.widx = in_ch.word_index;
		job.wdata = in_ch.word_data;
		job.walk = 1'b0;
		job.status = ST_DIRECT;
		if (xlate_on_q && !priv[1]) begin
			if (top != '0 && top != '1) job.status = ST_FAULT;
			else job.walk = 1'b1;
		end
	end

	assign job_valid = in_ch.valid;
	assign in_ch.ready = job_ready;
endmodule

// ===== rtl/sv39_fifo.sv =====
module sv39_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sv39_pkg::job_t in_job,
	output logic           out_valid,
	input  logic           out_ready,
	output sv39_pkg::job_t out_job
);
	import sv39_pkg::*;

	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_job = slot_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// store item in the free slot
	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= in_job;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/sv39_back.sv =====
module sv39_back #(
	parameter int STORE_WORDS = sv39_pkg::STORE_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sv39_pkg::cfg_t cfg,
	input  logic           job_valid,
	output logic           job_ready,
	input  sv39_pkg::job_t job,
	sv39_out_if.source     out_ch
);
	import sv39_pkg::*;

	localparam int AW = $clog2(STORE_WORDS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ADDR = 4'b0010,
		S_READ = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t      state_q;
	job_t        cur_q;
	logic [1:0]  level_q;
	logic [55:0] base_q;
	logic [63:0] mem_q [STORE_WORDS];
	logic [63:0] rdata_q;
	logic [AW-1:0] raddr_q;
	logic        ovalid_q;
	logic [1:0]  ost_q;
	logic [55:0] opa_q;

	logic [8:0]  idx;
	logic [52:0] word;
	logic        in_range;
	logic [31:0] widx_ext;
	logic        r, w, x, u, a, d, leaf, fault, align_bad, pte_bad;
	logic [55:0] pa;
	logic        res_set;
	logic [1:0]  res_st;
	logic [55:0] res_pa;

	// take next job when idle and the output slot is free or being emptied
	assign job_ready = (state_q == S_IDLE) && (!ovalid_q || out_ch.ready);

	// table index for the current level
	always_comb begin
		case (level_q)
			2'd2:    idx = cur_q.va[38:30];
			2'd1:    idx = cur_q.va[29:21];
			default: idx = cur_q.va[20:12];
		endcase
		word = base_q[55:3] + {44'd0, idx};
		in_range = (word < 53'(STORE_WORDS));
	end

	assign widx_ext = {20'd0, job.widx};

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && job_valid && job_ready && job.is_write &&
				widx_ext < 32'(STORE_WORDS))
			mem_q[widx_ext[AW-1:0]] <= job.wdata;
		raddr_q <= word[AW-1:0];
		rdata_q <= mem_q[raddr_q];
	end

	// PTE checks
	always_comb begin
		r = rdata_q[1]; w = rdata_q[2]; x = rdata_q[3];
		u = rdata_q[4]; a = rdata_q[6]; d = rdata_q[7];
		leaf = r || w || x;
		pte_bad = (rdata_q[63:54] != '0) || !rdata_q[0] || (w && !r);
		case (level_q)
			2'd2:    align_bad = (rdata_q[27:10] != '0);
			2'd1:    align_bad = (rdata_q[18:10] != '0);
			default: align_bad = 1'b0;
		endcase
		fault = 1'b0;
		if (cur_q.kind == KIND_FETCH) begin
			if (!x || (cur_q.priv == 2'd1 && u) || (cur_q.priv == 2'd0 && !u) || !a)
				fault = 1'b1;
		end else begin
			if (cur_q.kind == KIND_LOAD && !r && !(x && cfg.mxr)) fault = 1'b1;
			if (cur_q.kind == KIND_STORE && (!w || !d)) fault = 1'b1;
			if (cur_q.priv == 2'd1 && u && !cfg.sum) fault = 1'b1;
			if (cur_q.priv == 2'd0 && !u) fault = 1'b1;
			if (!a) fault = 1'b1;
		end
		case (level_q)
			2'd2:    pa = {rdata_q[53:28], cur_q.va[29:0]};
			2'd1:    pa = {rdata_q[53:19], cur_q.va[20:0]};
			default: pa = {rdata_q[53:10], cur_q.va[11:0]};
		endcase
	end

	// decide whether a result is produced this cycle
	always_comb begin
		res_set = 1'b0;
		res_st = ST_FAULT;
		res_pa = '0;
		case (state_q)
			S_IDLE: begin
				if (job_valid && job_ready && !job.is_write && !job.walk) begin
					res_set = 1'b1;
					res_st = job.status;
				end
			end
			S_ADDR: begin
				if (!in_range) res_set = 1'b1;
			end
			S_DONE: begin
				if (pte_bad || (!leaf && level_q == 2'd0) || (leaf && (align_bad || fault)))
					res_set = 1'b1;
				else if (leaf) begin
					res_set = 1'b1;
					res_st = ST_XLATE;
					res_pa = pa;
				end
			end
			default: ;
		endcase
	end

	// walk sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovalid_q <= 1'b0;
			ost_q <= ST_DIRECT;
			opa_q <= '0;
			cur_q <= '0;
			level_q <= 2'd0;
			base_q <= '0;
		end else begin
			if (res_set) begin
				ovalid_q <= 1'b1; ost_q <= res_st; opa_q <= res_pa;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid && job_ready) begin
						cur_q <= job;
						level_q <= 2'd2;
						base_q <= {cfg.root_ppn, 12'd0};
						if (!job.is_write && job.walk) state_q <= S_ADDR;
					end
				end
				S_ADDR: state_q <= in_range ? S_READ : S_IDLE;
				S_READ: state_q <= S_DONE;
				S_DONE: begin
					// descend to the next table on a valid pointer
					if (!pte_bad && !leaf && level_q != 2'd0) begin
						level_q <= level_q - 2'd1;
						base_q <= {rdata_q[53:10], 12'd0};
						state_q <= S_ADDR;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_ch.valid = ovalid_q;
	assign out_ch.status = ost_q;
	assign out_ch.phys_addr = opa_q;
endmodule

// ===== rtl/sv39_checker.sv =====
module sv39_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [55:0] phys_addr
);
	import sv39_pkg::*;

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_DIRECT || status == ST_XLATE || status == ST_FAULT))
		else $error("bad status");
	a_pa_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_XLATE |-> phys_addr == '0)
		else $error("phys_addr not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phys_addr))
		else $error("result dropped");
endmodule

bind sv39_page_walk_translate sv39_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.status(out_ch.status), .phys_addr(out_ch.phys_addr)
);

// ===== verif/tb_sv39_page_walk_translate.sv =====
module tb_sv39_page_walk_translate;
	timeunit 1ns;
	timeprecision 1ps;
	import sv39_pkg::*;

	localparam int WORDS = STORE_WORDS_DEF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 20;

	// PTE flag bits
	localparam logic [7:0] F_V = 8'h01;
	localparam logic [7:0] F_R = 8'h02;
	localparam logic [7:0] F_W = 8'h04;
	localparam logic [7:0] F_X = 8'h08;
	localparam logic [7:0] F_U = 8'h10;
	localparam logic [7:0] F_A = 8'h40;
	localparam logic [7:0] F_D = 8'h80;

	typedef struct {
		logic        opcode;
		logic [63:0] va;
		logic [1:0]  kind;
		logic [11:0] widx;
		logic [63:0] wdata;
	} item_t;

	typedef struct {
		logic [1:0]  status;
		logic [55:0] pa;
	} xlate_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [43:0] cfg_data;

	sv39_in_if  in_ch();
	sv39_out_if out_ch();

	sv39_page_walk_translate i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// shadow state of the translator
	logic [63:0] tbl_words [WORDS];
	logic        m_on;
	logic [43:0] m_root;
	logic [1:0]  m_cur, m_prev;
	logic        m_mprv, m_sum, m_mxr;

	item_t  pending_items[$];
	xlate_t expected_xlates[$];
	item_t  on_bus;
	int     src_idle_pct, snk_idle_pct;
	int     hold_req, hold_seen, hold_left;
	int     mismatches, idle_cycles, n_items;
	int     n_status[3];

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// walk the shadow tables for one translate
	function automatic xlate_t walk_tables(logic [63:0] va, logic [1:0] kind, logic [1:0] priv);
		xlate_t      r;
		logic [63:0] base, word, pte, idx;
		logic        fr, fw, fx, fu, fa, fd, st;
		int          sh;
		r.status = ST_FAULT;
		r.pa = '0;
		base = {20'b0, m_root} << 12;
		if (va[63:38] != '0 && va[63:38] != '1)
			return r;
		for (int lvl = 2; lvl >= 0; lvl--) begin
			sh = 12 + 9 * lvl;
			idx = (va >> sh) & 64'h1FF;
			word = (base >> 3) + idx;
			if (word >= WORDS)
				return r;
			pte = tbl_words[word];
			if (pte[63:54] != '0)
				return r;
			fr = pte[1]; fw = pte[2]; fx = pte[3]; fu = pte[4]; fa = pte[6]; fd = pte[7];
			if (!pte[0] || (fw && !fr))
				return r;
			if (!fr && !fw && !fx) begin
				base = {8'b0, pte[53:10], 12'b0};
				continue;
			end
			if (lvl != 0 && (((pte >> 10) & ((64'd1 << (9 * lvl)) - 1)) != 0))
				return r;
			if (kind == KIND_FETCH) begin
				if (!fx || (priv == 2'd1 && fu) || (priv == 2'd0 && !fu) || !fa)
					return r;
			end else begin
				st = (kind == KIND_STORE);
				if (!st && !fr && !(fx && m_mxr)) return r;
				if (st && !fw) return r;
				if (priv == 2'd1 && fu && !m_sum) return r;
				if (priv == 2'd0 && !fu) return r;
				if (!fa || (st && !fd)) return r;
			end
			r.status = ST_XLATE;
			r.pa = {pte[53:10], 12'b0} | 56'(va & ((64'd1 << sh) - 1));
			return r;
		end
		return r;
	endfunction

	// apply one accepted item to the shadow state; true when a result follows
	function automatic bit apply_item(item_t it, output xlate_t r);
		logic [1:0] kind, priv;
		r.status = ST_DIRECT;
		r.pa = '0;
		if (it.opcode == OP_WRITE) begin
			tbl_words[it.widx] = it.wdata;
			return 1'b0;
		end
		kind = (it.kind == 2'd3) ? KIND_LOAD : it.kind;
		priv = (kind != KIND_FETCH && m_mprv) ? m_prev : m_cur;
		if (m_on && priv <= 2'd1)
			r = walk_tables(it.va, kind, priv);
		return 1'b1;
	endfunction

	// drive input items from the pending queue
	always @(posedge clk or negedge arst_n) begin
		xlate_t r;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				n_items++;
				if (apply_item(on_bus, r))
					expected_xlates.push_back(r);
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
					on_bus = pending_items.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.opcode <= on_bus.opcode;
					in_ch.virt_addr <= on_bus.va;
					in_ch.access_kind <= on_bus.kind;
					in_ch.word_index <= on_bus.widx;
					in_ch.word_data <= on_bus.wdata;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// drive ready, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// check results and guard against a hang
	always @(posedge clk) begin
		xlate_t e;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (out_ch.valid && out_ch.ready) begin
				if (expected_xlates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d pa %h",
							out_ch.status, out_ch.phys_addr);
				end else begin
					e = expected_xlates.pop_front();
					if (out_ch.status < 3) n_status[out_ch.status]++;
					if (out_ch.status !== e.status || out_ch.phys_addr !== e.pa) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: status exp %0d got %0d, pa exp %h got %h",
								e.status, out_ch.status, e.pa, out_ch.phys_addr);
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no progress, %0d results outstanding",
					expected_xlates.size());
				$display("tb_sv39_page_walk_translate failed");
				$finish;
			end
		end
	end

	function automatic logic [63:0] mk_pte(logic [43:0] ppn, logic [7:0] flags);
		return {10'b0, ppn, 2'b0, flags};
	endfunction

	function automatic logic [63:0] canon_va();
		logic [63:0] va;
		va = {$urandom, $urandom};
		return {{26{va[37]}}, va[37:0]};
	endfunction

	task automatic push_write(logic [11:0] widx, logic [63:0] wdata);
		item_t it;
		it.opcode = OP_WRITE; it.va = {$urandom, $urandom};
		it.kind = 2'($urandom_range(3));
		it.widx = widx; it.wdata = wdata;
		pending_items.push_back(it);
	endtask

	task automatic push_xlate(logic [63:0] va, logic [1:0] kind);
		item_t it;
		it.opcode = OP_XLATE; it.va = va; it.kind = kind;
		it.widx = 12'($urandom); it.wdata = {$urandom, $urandom};
		pending_items.push_back(it);
	endtask

	// lay down pointers from the root down to a leaf at level lvl, then translate
	task automatic push_chain(logic [63:0] va, logic [1:0] kind, int lvl, logic [63:0] leaf);
		logic [2:0] pg, nxt;
		pg = m_root[2:0];
		for (int l = 2; l > lvl; l--) begin
			nxt = 3'($urandom_range(7));
			push_write({pg, va[12 + 9 * l +: 9]}, mk_pte({41'b0, nxt}, F_V));
			pg = nxt;
		end
		push_write({pg, va[12 + 9 * lvl +: 9]}, leaf);
		push_xlate(va, kind);
	endtask

	function automatic logic [63:0] rand_leaf(int lvl);
		logic [43:0] ppn;
		logic [7:0]  fl;
		logic [63:0] pte;
		ppn = 44'({$urandom, $urandom});
		if ($urandom_range(99) < 85 && lvl > 0)
			ppn = ppn & ~((44'd1 << (9 * lvl)) - 44'd1);
		fl = 8'($urandom);
		if ($urandom_range(99) < 95) fl |= F_V;
		if ($urandom_range(99) < 90) fl |= F_A;
		if (fl[2] && !fl[1] && $urandom_range(99) < 85) fl |= F_R;
		if ((fl & (F_R | F_W | F_X)) == 0) fl |= F_X;
		pte = mk_pte(ppn, fl);
		if ($urandom_range(99) < 5) pte[63:54] = 10'($urandom);
		return pte;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [43:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(logic on, logic [43:0] root, logic [1:0] cur, logic mprv,
		logic [1:0] prev, logic sm, logic mx);
		write_reg(CFG_XLATE_ON, {43'b0, on});
		write_reg(CFG_ROOT_PPN, root);
		write_reg(CFG_CUR_PRIV, {42'b0, cur});
		write_reg(CFG_MPRV, {43'b0, mprv});
		write_reg(CFG_PREV_PRIV, {42'b0, prev});
		write_reg(CFG_SUM, {43'b0, sm});
		write_reg(CFG_MXR, {43'b0, mx});
		m_on = on; m_root = root; m_cur = cur; m_mprv = mprv;
		m_prev = prev; m_sum = sm; m_mxr = mx;
	endtask

	// wait for all items and results, then let the block settle
	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (pending_items.size() > 0 || in_ch.valid || expected_xlates.size() > 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [1:0] kind;
		logic       on;
		logic [43:0] root;
		in_ch.valid = 1'b0; in_ch.opcode = 1'b0; in_ch.virt_addr = '0;
		in_ch.access_kind = '0; in_ch.word_index = '0; in_ch.word_data = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		arst_n = 1'b0;
		src_idle_pct = 0; snk_idle_pct = 0;
		hold_req = 0; hold_seen = 0; hold_left = 0;
		mismatches = 0; idle_cycles = 0; n_items = 0;
		n_status = '{0, 0, 0};
		m_on = 1'b0; m_root = '0; m_cur = 2'd3; m_mprv = 1'b0;
		m_prev = 2'd0; m_sum = 1'b0; m_mxr = 1'b0;
		foreach (tbl_words[i]) tbl_words[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: every access is direct
		push_xlate(64'h0, KIND_LOAD);
		push_xlate('1, KIND_FETCH);
		drain();

		// directed cases: supervisor, root at page zero; every walk reads only
		// words its own chain has written
		set_config(1'b1, 44'd0, 2'd1, 1'b0, 2'd0, 1'b0, 1'b0);
		push_xlate(64'h0000_0040_0000_0000, KIND_LOAD);   // bit 38 alone: non-canonical
		push_xlate(64'h8000_0000_0000_0000, KIND_STORE);
		push_chain(64'h0000_0000_0012_3456, KIND_LOAD, 0, mk_pte(44'h5, F_V | F_R | F_A));
		push_chain(canon_va(), KIND_STORE, 0, mk_pte(44'h7, F_V | F_R | F_W | F_A));
		push_chain(canon_va(), KIND_STORE, 0, mk_pte(44'h7, F_V | F_R | F_W | F_A | F_D));
		push_chain(canon_va(), KIND_FETCH, 1, mk_pte(44'h200, F_V | F_X | F_A));
		push_chain(canon_va(), 2'd3, 0, mk_pte('1, F_V | F_R | F_A));
		push_chain(canon_va(), KIND_LOAD, 0, 64'hFFC0_0000_0000_00CF);  // reserved bits
		push_chain(canon_va(), KIND_LOAD, 0, mk_pte(44'h3, F_V));        // pointer at level 0
		push_chain(canon_va(), KIND_LOAD, 2, mk_pte(44'h1, F_V | F_R | F_A)); // misaligned
		push_chain(canon_va(), KIND_LOAD, 1, mk_pte(44'h3, F_R | F_A));       // V clear
		push_chain(canon_va(), KIND_STORE, 0, mk_pte(44'h3, F_V | F_W | F_A | F_D));
		push_chain(canon_va(), KIND_LOAD, 0, mk_pte(44'h3, F_V | F_R | F_U | F_A));
		push_chain(canon_va(), KIND_LOAD, 1, mk_pte(44'h8, F_V));      // next table off the end
		push_chain(64'hFFFF_FFFF_FFFF_FFFF, KIND_LOAD, 2, mk_pte(44'h0, F_V | F_R | F_A));
		drain();

		// random phases through a range of settings
		for (int ph = 0; ph < 8; ph++) begin
			on = ($urandom_range(99) < 85);
			root = 44'($urandom_range(7));
			case (ph)
				0: set_config(1'b1, '1, 2'd1, 1'b0, 2'd0, 1'b1, 1'b1);
				1: set_config(1'b1, 44'd0, 2'd0, 1'b1, 2'd3, 1'b0, 1'b1);
				2: set_config(1'b1, 44'd7, 2'd3, 1'b1, 2'd1, 1'b1, 1'b0);
				default: set_config(on, root, 2'($urandom_range(3)), 1'($urandom_range(1)),
					2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
			endcase
			src_idle_pct = (ph < 3) ? 29 : (ph < 6) ? 73 : 0;
			snk_idle_pct = (ph < 3) ? 73 : (ph < 6) ? 29 : 0;
			if (ph == 3) hold_req++;
			for (int n = 0; n < 16; n++) begin
				kind = 2'($urandom_range(3));
				if ($urandom_range(99) < 80) begin
					int lvl;
					lvl = $urandom_range(2);
					push_chain(canon_va(), kind, lvl, rand_leaf(lvl));
				end else if ($urandom_range(1)) begin
					// top bits differ, so this never walks the tables
					push_xlate({2'b01, 30'($urandom), $urandom}, kind);
				end else begin
					push_write(12'($urandom), {$urandom, $urandom});
				end
			end
			drain();
		end

		$display("covered %0d items: %0d direct, %0d translated, %0d faults",
			n_items, n_status[0], n_status[1], n_status[2]);
		$display("reset, directed and eight random settings, including a long receiver hold-off");
		if (mismatches == 0 && expected_xlates.size() == 0)
			$display("tb_sv39_page_walk_translate passed");
		else
			$display("tb_sv39_page_walk_translate failed");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/sv39_pkg.sv
rtl/sv39_if.sv
rtl/sv39_front.sv
rtl/sv39_fifo.sv
rtl/sv39_back.sv
rtl/sv39_page_walk_translate.sv
rtl/sv39_checker.sv
verif/tb_sv39_page_walk_translate.sv
